/* rtl/core/wlt_pkg.sv */
// ----------------------------------------------------------------------------
// Windowed level tracker package
// Shared widths, register indexes and the window record type.
// ----------------------------------------------------------------------------
package wlt_pkg;

  localparam int unsigned SAMPLE_BITS   = 12;
  localparam int unsigned COUNT_BITS    = 20;
  localparam int unsigned SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned WINDOW_BITS   = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned STEP_BITS     = $clog2(SUM_BITS);

  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0]  COUNT_LIMIT    = {COUNT_BITS{1'b1}};
  localparam logic [WINDOW_BITS-1:0] WINDOW_MS_RST  = WINDOW_BITS'(100);
  localparam logic [SAMPLE_BITS-1:0] LOUD_THR_RST   = '0;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_MS = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOUD_THR  = CFG_IDX_BITS'(1);

  // closed window as handed from the front to the back
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] last_sample;
    logic [SAMPLE_BITS-1:0] win_min;
    logic [SAMPLE_BITS-1:0] win_max;
    logic [SUM_BITS-1:0]    sum;
    logic [COUNT_BITS-1:0]  count;
    logic [TIME_BITS-1:0]   closed_at;
  } rec_t;

  // queue handshake towards one side
  typedef struct packed {
    logic push;
    logic pop;
  } qreq_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* rtl/core/wlt_front.sv */
// ----------------------------------------------------------------------------
// Windowed level tracker front
// Holds the configuration and the open window, folds each sample into it and
// hands closed windows to the record queue.
// ----------------------------------------------------------------------------
module wlt_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wlt_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [wlt_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               accept_i,
  input  logic [wlt_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic [wlt_pkg::TIME_BITS-1:0]      now_ms_i,
  output logic                               enq_o,
  output wlt_pkg::rec_t                      rec_o,
  output logic [wlt_pkg::SAMPLE_BITS-1:0]    loud_thr_o
);

  logic [wlt_pkg::WINDOW_BITS-1:0] win_ms_q, win_ms_d;
  logic [wlt_pkg::SAMPLE_BITS-1:0] thr_q, thr_d;
  logic                            known_q, known_d;
  logic [wlt_pkg::TIME_BITS-1:0]   start_q, start_d;
  logic [wlt_pkg::SUM_BITS-1:0]    sum_q, sum_d;
  logic [wlt_pkg::COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic [wlt_pkg::SAMPLE_BITS-1:0] min_q, min_d;
  logic [wlt_pkg::SAMPLE_BITS-1:0] max_q, max_d;

  logic [wlt_pkg::TIME_BITS-1:0]   start;
  logic [wlt_pkg::TIME_BITS-1:0]   elapsed;
  logic [wlt_pkg::SAMPLE_BITS-1:0] min_n, max_n;
  logic [wlt_pkg::SUM_BITS-1:0]    sum_n;
  logic [wlt_pkg::COUNT_BITS-1:0]  cnt_n;
  logic                            first, close;
  logic                            cfg_hit;

  always_comb begin
    start   = known_q ? start_q : now_ms_i;
    first   = (cnt_q == '0);
    min_n   = (first || (sample_i < min_q)) ? sample_i : min_q;
    max_n   = (first || (sample_i > max_q)) ? sample_i : max_q;
    sum_n   = sum_q + wlt_pkg::SUM_BITS'(sample_i);
    cnt_n   = cnt_q + 1'b1;
    elapsed = now_ms_i - start;
    close   = (win_ms_q == '0) ||
              (elapsed >= wlt_pkg::TIME_BITS'(win_ms_q)) ||
              (cnt_n == wlt_pkg::COUNT_LIMIT);
  end

  assign enq_o = accept_i & close;

  always_comb begin
    rec_o.last_sample = sample_i;
    rec_o.win_min     = min_n;
    rec_o.win_max     = max_n;
    rec_o.sum         = sum_n;
    rec_o.count       = cnt_n;
    rec_o.closed_at   = now_ms_i;
  end

  assign loud_thr_o = thr_q;

  always_comb begin
    win_ms_d = win_ms_q;
    thr_d    = thr_q;
    known_d  = known_q;
    start_d  = start_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    min_d    = min_q;
    max_d    = max_q;
    cfg_hit  = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wlt_pkg::CFG_WINDOW_MS: begin
          win_ms_d = cfg_data_i[wlt_pkg::WINDOW_BITS-1:0];
          cfg_hit  = 1'b1;
        end
        wlt_pkg::CFG_LOUD_THR: begin
          thr_d   = cfg_data_i[wlt_pkg::SAMPLE_BITS-1:0];
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end

    if (cfg_hit) begin
      // drop the open window; next sample restarts timing
      known_d = 1'b0;
      start_d = '0;
      sum_d   = '0;
      cnt_d   = '0;
    end else if (accept_i) begin
      known_d = 1'b1;
      if (close) begin
        start_d = now_ms_i;
        sum_d   = '0;
        cnt_d   = '0;
      end else begin
        start_d = start;
        sum_d   = sum_n;
        cnt_d   = cnt_n;
        min_d   = min_n;
        max_d   = max_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_ms_q <= wlt_pkg::WINDOW_MS_RST;
      thr_q    <= wlt_pkg::LOUD_THR_RST;
      known_q  <= 1'b0;
      start_q  <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
    end else begin
      win_ms_q <= win_ms_d;
      thr_q    <= thr_d;
      known_q  <= known_d;
      start_q  <= start_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    max_q <= max_d;
  end

endmodule

/* rtl/core/wlt_queue.sv */
// ----------------------------------------------------------------------------
// Windowed level tracker record queue
// Short register queue of closed windows between front and back.
// ----------------------------------------------------------------------------
module wlt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wlt_pkg::qreq_t req_i,
  input  wlt_pkg::rec_t  rec_i,
  output wlt_pkg::qstat_t stat_o,
  output wlt_pkg::rec_t  rec_o
);

  wlt_pkg::rec_t                  mem_q [wlt_pkg::QUEUE_DEPTH];
  logic [wlt_pkg::QPTR_BITS-1:0]  wr_q, wr_d;
  logic [wlt_pkg::QPTR_BITS-1:0]  rd_q, rd_d;
  logic [wlt_pkg::QCNT_BITS-1:0]  cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign stat_o.full  = (cnt_q == wlt_pkg::QCNT_BITS'(wlt_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign rec_o        = mem_q[rd_q];

  assign do_push = req_i.push & ~stat_o.full;
  assign do_pop  = req_i.pop & ~stat_o.empty;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == wlt_pkg::QPTR_BITS'(wlt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == wlt_pkg::QPTR_BITS'(wlt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule

/* rtl/core/wlt_back.sv */
// ----------------------------------------------------------------------------
// Windowed level tracker back
// Takes closed windows from the queue, divides sum by count one bit per
// cycle and loads the finished word into the output register.
// ----------------------------------------------------------------------------
module wlt_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wlt_pkg::qstat_t                   qstat_i,
  input  wlt_pkg::rec_t                     rec_i,
  input  logic [wlt_pkg::SAMPLE_BITS-1:0]   loud_thr_i,
  output logic                              qpop_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic [wlt_pkg::SAMPLE_BITS-1:0]   last_sample_o,
  output logic [wlt_pkg::SAMPLE_BITS-1:0]   window_min_o,
  output logic [wlt_pkg::SAMPLE_BITS-1:0]   window_max_o,
  output logic [wlt_pkg::SAMPLE_BITS-1:0]   mean_level_o,
  output logic [wlt_pkg::SAMPLE_BITS-1:0]   peak_to_peak_o,
  output logic [wlt_pkg::COUNT_BITS-1:0]    samples_in_window_o,
  output logic [wlt_pkg::TIME_BITS-1:0]     closed_at_ms_o,
  output logic                              loud_o
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_DONE = 3'b100
  } bk_state_e;

  bk_state_e state_q, state_d;

  wlt_pkg::rec_t                   work_q;
  logic [wlt_pkg::SAMPLE_BITS-1:0] p2p_q;
  logic                            loud_q;
  logic [wlt_pkg::SUM_BITS-1:0]    dvd_q, dvd_d;
  logic [wlt_pkg::COUNT_BITS-1:0]  rem_q, rem_d;
  logic [wlt_pkg::SAMPLE_BITS-1:0] quo_q, quo_d;
  logic [wlt_pkg::STEP_BITS-1:0]   step_q, step_d;

  logic                            out_vld_q, out_vld_d;
  logic                            take, load, out_pop;
  logic [wlt_pkg::COUNT_BITS:0]    rem_sh;
  logic                            fits;
  logic [wlt_pkg::SAMPLE_BITS-1:0] p2p_n;

  assign empty_o = ~out_vld_q;
  assign out_pop = pop_i & out_vld_q;
  assign take    = (state_q == BK_IDLE) & ~qstat_i.empty;
  assign load    = (state_q == BK_DONE) & (~out_vld_q | out_pop);
  assign qpop_o  = take;
  assign p2p_n   = rec_i.win_max - rec_i.win_min;

  // restoring divide step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_q, dvd_q[wlt_pkg::SUM_BITS-1]};
    fits   = (rem_sh >= {1'b0, work_q.count});
  end

  always_comb begin
    state_d   = state_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    step_d    = step_q;
    out_vld_d = out_vld_q;

    if (out_pop) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      BK_IDLE: begin
        if (take) begin
          dvd_d   = rec_i.sum;
          rem_d   = '0;
          quo_d   = '0;
          step_d  = '0;
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        dvd_d  = {dvd_q[wlt_pkg::SUM_BITS-2:0], 1'b0};
        rem_d  = fits ? wlt_pkg::COUNT_BITS'(rem_sh - {1'b0, work_q.count})
                      : rem_sh[wlt_pkg::COUNT_BITS-1:0];
        quo_d  = {quo_q[wlt_pkg::SAMPLE_BITS-2:0], fits};
        step_d = step_q + 1'b1;
        if (step_q == wlt_pkg::STEP_BITS'(wlt_pkg::SUM_BITS - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (load) begin
          out_vld_d = 1'b1;
          state_d   = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (take) begin
      work_q <= rec_i;
      p2p_q  <= p2p_n;
      loud_q <= (p2p_n >= loud_thr_i);
    end
    if (load) begin
      last_sample_o       <= work_q.last_sample;
      window_min_o        <= work_q.win_min;
      window_max_o        <= work_q.win_max;
      mean_level_o        <= quo_q;
      peak_to_peak_o      <= p2p_q;
      samples_in_window_o <= work_q.count;
      closed_at_ms_o      <= work_q.closed_at;
      loud_o              <= loud_q;
    end
  end

endmodule

/* rtl/core/windowed_level_tracker_top.sv */
// ----------------------------------------------------------------------------
// Windowed level tracker
// Tracks min, max, mean and peak-to-peak of ADC samples over time windows.
// ----------------------------------------------------------------------------
// Input side: drive sample_i and now_ms_i with push; the word is taken on a
// clock edge with push high and full low. Each sample is folded into the
// open window in the cycle it is taken; a sample that closes the window
// drops a record into a two-deep queue, and full rises only while that
// queue is full.
// Result side: while empty is low the oldest closed window sits on the
// result ports; pop on such an edge takes it. A record is picked up from
// the queue, runs through the bit-serial sum/count divider and is then
// loaded into the output register; the next record is picked up only once
// that load is done. A stalled receiver holds the output register; the
// divider and the queue keep working behind it until the queue fills and
// full rises.
// Configuration: cfg_we_i with cfg_idx_i 0 (window_ms) or 1 (loud
// threshold); write only while idle. A write to either register drops the open window.
// Reset: window_ms is 100, threshold 0, queue and output empty; the first
// sample after reset or a write starts the window clock.
// ----------------------------------------------------------------------------
module windowed_level_tracker_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wlt_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [wlt_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               push,
  output logic                               full,
  input  logic [wlt_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic [wlt_pkg::TIME_BITS-1:0]      now_ms_i,
  input  logic                               pop,
  output logic                               empty,
  output logic [wlt_pkg::SAMPLE_BITS-1:0]    last_sample_o,
  output logic [wlt_pkg::SAMPLE_BITS-1:0]    window_min_o,
  output logic [wlt_pkg::SAMPLE_BITS-1:0]    window_max_o,
  output logic [wlt_pkg::SAMPLE_BITS-1:0]    mean_level_o,
  output logic [wlt_pkg::SAMPLE_BITS-1:0]    peak_to_peak_o,
  output logic [wlt_pkg::COUNT_BITS-1:0]     samples_in_window_o,
  output logic [wlt_pkg::TIME_BITS-1:0]      closed_at_ms_o,
  output logic                               loud_o
);

  wlt_pkg::qreq_t                  qreq;
  wlt_pkg::qstat_t                 qstat;
  wlt_pkg::rec_t                   rec_in, rec_out;
  logic                            accept;
  logic                            enq, deq;
  logic [wlt_pkg::SAMPLE_BITS-1:0] loud_thr;

  assign full   = qstat.full;
  assign accept = push & ~qstat.full;

  assign qreq.push = enq;
  assign qreq.pop  = deq;

  wlt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .sample_i   (sample_i),
    .now_ms_i   (now_ms_i),
    .enq_o      (enq),
    .rec_o      (rec_in),
    .loud_thr_o (loud_thr)
  );

  wlt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (qreq),
    .rec_i  (rec_in),
    .stat_o (qstat),
    .rec_o  (rec_out)
  );

  wlt_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .qstat_i             (qstat),
    .rec_i               (rec_out),
    .loud_thr_i          (loud_thr),
    .qpop_o              (deq),
    .pop_i               (pop),
    .empty_o             (empty),
    .last_sample_o       (last_sample_o),
    .window_min_o        (window_min_o),
    .window_max_o        (window_max_o),
    .mean_level_o        (mean_level_o),
    .peak_to_peak_o      (peak_to_peak_o),
    .samples_in_window_o (samples_in_window_o),
    .closed_at_ms_o      (closed_at_ms_o),
    .loud_o              (loud_o)
  );

endmodule

/* tb/windowed_level_tracker_top_tb.sv */
// ----------------------------------------------------------------------------
// Windowed level tracker testbench
// Drives ADC sample words with timestamps into the tracker and checks every
// closed window (min, max, mean, peak-to-peak, count, close time, loud flag)
// against a cycle-free predictor. A directed part covers field extremes,
// time wrap, backward time, zero-length windows, register masking and unused
// register indexes; random phases follow under several register settings
// with random idling on both sides.
// ----------------------------------------------------------------------------
module windowed_level_tracker_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SB = wlt_pkg::SAMPLE_BITS;
  localparam int unsigned CB = wlt_pkg::COUNT_BITS;
  localparam int unsigned TB = wlt_pkg::TIME_BITS;

  // register indexes that decode to nothing
  localparam logic [wlt_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [wlt_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

  localparam int SETTLE_CYCLES = 50;
  localparam int LIMIT_CYCLES  = 200_000;

  typedef struct packed {
    logic [SB-1:0] last_sample;
    logic [SB-1:0] win_min;
    logic [SB-1:0] win_max;
    logic [SB-1:0] mean;
    logic [SB-1:0] p2p;
    logic [CB-1:0] count;
    logic [TB-1:0] closed_at;
    logic          loud;
  } window_rec_t;

  class window_stats_sb;
    logic [wlt_pkg::WINDOW_BITS-1:0] win_len;
    logic [SB-1:0]                   loud_thr;
    logic [TB-1:0]                   win_start;
    bit                              start_valid;
    logic [63:0]                     acc_sum;
    logic [CB-1:0]                   acc_count;
    logic [SB-1:0]                   acc_min;
    logic [SB-1:0]                   acc_max;
    window_rec_t                     closed_windows[$];
    int                              errors;

    function new();
      win_len     = wlt_pkg::WINDOW_MS_RST;
      loud_thr    = wlt_pkg::LOUD_THR_RST;
      start_valid = 0;
      errors      = 0;
      restart(0);
    endfunction

    function void restart(logic [TB-1:0] t);
      win_start = t;
      acc_sum   = '0;
      acc_count = '0;
      acc_min   = '0;
      acc_max   = '0;
    endfunction

    function void write_reg(logic [wlt_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [wlt_pkg::CFG_DATA_BITS-1:0] data);
      if (idx == wlt_pkg::CFG_WINDOW_MS) begin
        win_len = data[wlt_pkg::WINDOW_BITS-1:0];
      end else if (idx == wlt_pkg::CFG_LOUD_THR) begin
        loud_thr = data[SB-1:0];
      end else begin
        return;
      end
      start_valid = 0;
      restart(0);
    endfunction

    function void note_sample(logic [SB-1:0] s, logic [TB-1:0] t);
      logic [TB-1:0] elapsed;
      window_rec_t   rec;
      if (!start_valid) begin
        start_valid = 1;
        restart(t);
      end
      if (acc_count == 0) begin
        acc_min = s;
        acc_max = s;
      end else begin
        if (s < acc_min) acc_min = s;
        if (s > acc_max) acc_max = s;
      end
      acc_sum   = acc_sum + s;
      acc_count = acc_count + 1'b1;
      elapsed   = t - win_start;
      if (win_len != 0 && elapsed < win_len && acc_count < wlt_pkg::COUNT_LIMIT) return;
      rec.last_sample = s;
      rec.win_min     = acc_min;
      rec.win_max     = acc_max;
      rec.mean        = SB'(acc_sum / acc_count);
      rec.p2p         = acc_max - acc_min;
      rec.count       = acc_count;
      rec.closed_at   = t;
      rec.loud        = (rec.p2p >= loud_thr);
      closed_windows.push_back(rec);
      restart(t);
    endfunction

    function int pending();
      return closed_windows.size();
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_window(window_rec_t got);
      window_rec_t want;
      if (closed_windows.size() == 0) begin
        errors++;
        $display("%0t: window result with none expected, actual %p", $time, got);
        return;
      end
      want = closed_windows.pop_front();
      check_field("last_sample", want.last_sample, got.last_sample);
      check_field("window_min", want.win_min, got.win_min);
      check_field("window_max", want.win_max, got.win_max);
      check_field("mean_level", want.mean, got.mean);
      check_field("peak_to_peak", want.p2p, got.p2p);
      check_field("samples_in_window", want.count, got.count);
      check_field("closed_at_ms", want.closed_at, got.closed_at);
      check_field("loud", want.loud, got.loud);
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [wlt_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [wlt_pkg::CFG_DATA_BITS-1:0] cfg_data_i;
  logic                              push;
  logic                              full;
  logic [SB-1:0]                     sample_i;
  logic [TB-1:0]                     now_ms_i;
  logic                              pop;
  logic                              empty;
  logic [SB-1:0]                     last_sample_o;
  logic [SB-1:0]                     window_min_o;
  logic [SB-1:0]                     window_max_o;
  logic [SB-1:0]                     mean_level_o;
  logic [SB-1:0]                     peak_to_peak_o;
  logic [CB-1:0]                     samples_in_window_o;
  logic [TB-1:0]                     closed_at_ms_o;
  logic                              loud_o;

  window_stats_sb win_pred;
  bit             calm;
  int             stall_left;
  int             cycles;

  windowed_level_tracker_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .push                (push),
    .full                (full),
    .sample_i            (sample_i),
    .now_ms_i            (now_ms_i),
    .pop                 (pop),
    .empty               (empty),
    .last_sample_o       (last_sample_o),
    .window_min_o        (window_min_o),
    .window_max_o        (window_max_o),
    .mean_level_o        (mean_level_o),
    .peak_to_peak_o      (peak_to_peak_o),
    .samples_in_window_o (samples_in_window_o),
    .closed_at_ms_o      (closed_at_ms_o),
    .loud_o              (loud_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d windows outstanding", cycles, win_pred.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: stalls at random in bursts, none once calm
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop        <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      win_pred.check_window('{last_sample_o, window_min_o, window_max_o, mean_level_o,
                              peak_to_peak_o, samples_in_window_o, closed_at_ms_o,
                              loud_o});
    end
  end

  task automatic send_sample(input logic [SB-1:0] s, input logic [TB-1:0] t,
                             input bit may_idle);
    if (may_idle && !calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    push     <= 1'b1;
    sample_i <= s;
    now_ms_i <= t;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    win_pred.note_sample(s, t);
  endtask

  // hold the sender until every closed window has been taken
  task automatic drain();
    push <= 1'b0;
    while (win_pred.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [wlt_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [wlt_pkg::CFG_DATA_BITS-1:0] data);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    win_pred.write_reg(idx, data);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    // first word after reset starts the clock; the close wraps past 2^32
    send_sample(12'hFFF, 32'hFFFF_FFF0, 0);
    send_sample(12'h000, 32'h0000_0010, 0);
    send_sample(12'h800, 32'h0000_0054, 0);
    // time going backward reads as a huge elapsed time
    send_sample(12'h007, 32'h0000_0050, 0);
    send_sample(12'h123, 32'h0000_0060, 0);
    // zero-length windows close on every word
    write_reg(wlt_pkg::CFG_WINDOW_MS, 16'd0);
    send_sample(12'h000, 32'h0000_0000, 0);
    send_sample(12'hFFF, 32'hFFFF_FFFF, 0);
    send_sample(12'hA5A, 32'hFFFF_FFFF, 0);
    // threshold keeps only its low 12 bits
    write_reg(wlt_pkg::CFG_LOUD_THR, 16'hFFFF);
    write_reg(wlt_pkg::CFG_WINDOW_MS, 16'd10);
    send_sample(12'h000, 32'd5, 0);
    send_sample(12'hFFF, 32'd6, 0);
    send_sample(12'h100, 32'd15, 0);
    send_sample(12'hFFE, 32'd16, 0);
    send_sample(12'h001, 32'd17, 0);
    send_sample(12'h555, 32'd26, 0);
    // unused indexes leave the open window alone
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    send_sample(12'h3C3, 32'd30, 0);
    write_reg(CFG_SPARE_HI, 16'h0001);
    send_sample(12'hC3C, 32'd35, 0);
    write_reg(wlt_pkg::CFG_WINDOW_MS, 16'hFFFF);
    send_sample(12'h000, 32'd0, 0);
    send_sample(12'hFFF, 32'd65534, 0);
    send_sample(12'h800, 32'd65535, 0);
  endtask

  task automatic run_random(input int n, input logic [15:0] win,
                            input logic [15:0] thr, input bit hold_mid);
    logic [TB-1:0] t;
    logic [SB-1:0] s;
    int            span;
    int            i;
    int            pick;
    write_reg(wlt_pkg::CFG_WINDOW_MS, win);
    write_reg(wlt_pkg::CFG_LOUD_THR, thr);
    t    = $urandom();
    span = (win == 0) ? 40 : int'(win) / 3 + 1;
    for (i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 80) t = t + $urandom_range(0, span);
      else if (pick < 88) t = t + $urandom();
      else if (pick < 94) t = t - $urandom_range(1, 200);
      pick = $urandom_range(0, 19);
      if (pick == 0) s = '0;
      else if (pick == 1) s = '1;
      else s = SB'($urandom());
      send_sample(s, t, 1);
    end
  endtask

  initial begin
    win_pred   = new();
    calm       = 0;
    stall_left = 0;
    cycles     = 0;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    push       = 1'b0;
    pop        = 1'b0;
    sample_i   = '0;
    now_ms_i   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(65, 16'd0, 16'($urandom_range(0, 4095)), 1);
    run_random(65, 16'd1, 16'd0, 0);
    run_random(65, 16'hFFFF, 16'($urandom_range(0, 4095)), 0);
    run_random(65, 16'($urandom_range(2, 500)), 16'hFFFF, 0);
    run_random(65, 16'($urandom_range(1, 60)), 16'($urandom()), 0);
    calm = 1;
    run_random(65, 16'($urandom_range(0, 30)), 16'($urandom_range(0, 2048)), 0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (win_pred.errors == 0 && win_pred.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/wlt_pkg.sv
rtl/core/wlt_front.sv
rtl/core/wlt_queue.sv
rtl/core/wlt_back.sv
rtl/core/windowed_level_tracker_top.sv
tb/windowed_level_tracker_top_tb.sv
